[rtl/core/lmw_pkg.sv]
// ----------------------------------------------------------------------------
// lmw_pkg
// shared constants and types of the label majority window filter
// ----------------------------------------------------------------------------
package lmw_pkg;

  localparam int unsigned WINDOW_LEN_DEF  = 47;
  localparam int unsigned NUM_CLASSES_DEF = 7;
  localparam int unsigned LABEL_W         = 3;
  localparam int unsigned THR_W           = 6;

  localparam logic [THR_W-1:0] THR_RESET  = 6'd24;

  // request from the window control to the class count bank
  typedef struct packed {
    logic               step;        // input transfer this cycle
    logic               full;        // window reaches full length with this label
    logic               clear;       // final label of the sequence, counts restart
    logic [LABEL_W-1:0] in_lab;      // incoming label, already range checked
    logic [LABEL_W-1:0] emit_lab;    // label leaving the window
    logic [LABEL_W-1:0] centre_lab;  // label about to land on the centre cell
  } vote_req_t;

  // answer from the class count bank
  typedef struct packed {
    logic               ovr;         // overwrite the centre label
    logic [LABEL_W-1:0] best;        // majority class
  } vote_rsp_t;

endpackage

[rtl/core/lmw_cell.sv]
// ----------------------------------------------------------------------------
// lmw_cell
// one position of the label window: label and valid, shifted from its neighbour
// ----------------------------------------------------------------------------
module lmw_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic [lmw_pkg::LABEL_W-1:0]  prev_label,
  input  logic                         prev_vld,
  input  logic                         ovr_en,
  input  logic [lmw_pkg::LABEL_W-1:0]  ovr_label,
  output logic [lmw_pkg::LABEL_W-1:0]  label,
  output logic                         vld
);

  logic [lmw_pkg::LABEL_W-1:0] label_r;
  logic                        vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= prev_vld;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      label_r <= ovr_en ? ovr_label : prev_label;
    end
  end

  assign label = label_r;
  assign vld   = vld_r;

endmodule

[rtl/core/lmw_vote.sv]
// ----------------------------------------------------------------------------
// lmw_vote
// per-class label counts, majority search and centre overwrite decision
// ----------------------------------------------------------------------------
module lmw_vote #(
  parameter int unsigned WINDOW_LEN  = lmw_pkg::WINDOW_LEN_DEF,
  parameter int unsigned NUM_CLASSES = lmw_pkg::NUM_CLASSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lmw_pkg::vote_req_t          req,
  input  logic [lmw_pkg::THR_W-1:0]   thr,
  output lmw_pkg::vote_rsp_t          rsp
);

  localparam int unsigned CW    = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CMP_W = (CW > lmw_pkg::THR_W) ? CW : lmw_pkg::THR_W;

  logic [CW-1:0]               cnt_r   [NUM_CLASSES];
  logic [CW-1:0]               cnt_nxt [NUM_CLASSES];
  logic [CW-1:0]               aug     [NUM_CLASSES];
  logic [lmw_pkg::LABEL_W-1:0] best;
  logic [CW-1:0]               best_cnt;
  logic                        ovr;

  // counts including the incoming label
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      aug[c] = cnt_r[c] + CW'(req.in_lab == lmw_pkg::LABEL_W'(c));
    end
  end

  // lowest class wins a tie
  always_comb begin
    best     = '0;
    best_cnt = aug[0];
    for (int c = 1; c < NUM_CLASSES; c++) begin
      if (aug[c] > best_cnt) begin
        best     = lmw_pkg::LABEL_W'(c);
        best_cnt = aug[c];
      end
    end
  end

  assign ovr = req.full && (best != '0) && (CMP_W'(best_cnt) >= CMP_W'(thr))
               && (req.centre_lab != best);

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cnt_nxt[c] = aug[c]
                   - CW'(req.full && (req.emit_lab == lmw_pkg::LABEL_W'(c)))
                   - CW'(ovr && (req.centre_lab == lmw_pkg::LABEL_W'(c)))
                   + CW'(ovr && (best == lmw_pkg::LABEL_W'(c)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c] <= '0;
      end
    end else if (req.step) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c] <= req.clear ? '0 : cnt_nxt[c];
      end
    end
  end

  assign rsp.ovr  = ovr;
  assign rsp.best = best;

endmodule

[rtl/core/label_majority_window_filter_unit.sv]
// ----------------------------------------------------------------------------
// label_majority_window_filter_unit
// sliding-window majority filter over a stream of class labels
// ----------------------------------------------------------------------------
// throughput: one label per cycle while streaming and not stalled by out_ready;
//   the oldest label moves to the output register in the same cycle the new one
//   is transferred; a label leaves the chain WINDOW_LEN-1 input transfers after
//   it arrived, then passes through the output register; after a final label the
//   chain drains with in_ready low, and waits while out_ready stalls
// reset (rst_n, synchronous, active low): chain and counts empty, threshold 24
// ----------------------------------------------------------------------------
module label_majority_window_filter_unit #(
  parameter int unsigned WINDOW_LEN  = lmw_pkg::WINDOW_LEN_DEF,
  parameter int unsigned NUM_CLASSES = lmw_pkg::NUM_CLASSES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [lmw_pkg::THR_W-1:0]    cfg_wr_data,
  // input label stream
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lmw_pkg::LABEL_W-1:0]  in_label,
  input  logic                         in_last,
  // filtered label stream
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lmw_pkg::LABEL_W-1:0]  out_label,
  output logic                         out_last
);

  // the chain holds WINDOW_LEN-1 labels, cell 0 newest; the oldest label of a
  // full window is the one shifted out of the top cell into the output register
  localparam int unsigned NCELL  = WINDOW_LEN - 1;
  localparam int unsigned TOP    = NCELL - 1;
  // centre position counted from the oldest, as a cell index after the shift
  localparam int unsigned CENTRE = WINDOW_LEN - 1 - WINDOW_LEN / 2;
  localparam int unsigned LW     = lmw_pkg::LABEL_W;

  // threshold register
  logic [lmw_pkg::THR_W-1:0] thr_r;

  // control and output register
  logic          flush_r, flush_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_label_r, out_label_nxt;
  logic          out_last_r, out_last_nxt;

  // cell chain
  logic [LW-1:0]    cell_label [NCELL];
  logic [NCELL-1:0] cell_vld;

  logic          slot_free;
  logic          acc;
  logic          full;
  logic          shift_en;
  logic [LW-1:0] lab;
  logic          head_vld;
  logic [LW-1:0] head_label;
  logic          flush_emit;
  logic          flush_done;

  lmw_pkg::vote_req_t vote_req;
  lmw_pkg::vote_rsp_t vote_rsp;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= lmw_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------- handshake
  // output register free, or being emptied in this cycle
  assign slot_free = !out_valid_r || out_ready;
  // no input while the chain drains after a final label
  assign in_ready  = !flush_r && slot_free;
  assign acc       = in_valid && in_ready;

  // out-of-range labels count as background
  assign lab = ({1'b0, in_label} < (LW + 1)'(NUM_CLASSES)) ? in_label : '0;

  // top cell valid means the new label completes a full window
  assign full = cell_vld[TOP];

  // drain step: the top label leaves, the last one when the cell below is empty
  assign flush_emit = flush_r && slot_free && cell_vld[TOP];
  assign flush_done = flush_emit && ((TOP == 0) ? 1'b1 : !cell_vld[(TOP == 0) ? 0 : TOP - 1]);

  assign shift_en   = acc || (flush_r && slot_free);
  assign head_vld   = acc;
  assign head_label = lab;

  // ---------------------------------------------------------------- cell chain
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    lmw_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .prev_label ((k == 0) ? head_label : cell_label[(k == 0) ? 0 : k - 1]),
      .prev_vld   ((k == 0) ? head_vld   : cell_vld[(k == 0) ? 0 : k - 1]),
      .ovr_en     ((k == CENTRE) ? (acc && vote_rsp.ovr) : 1'b0),
      .ovr_label  (vote_rsp.best),
      .label      (cell_label[k]),
      .vld        (cell_vld[k])
    );
  end

  // ---------------------------------------------------------------- counts
  always_comb begin
    vote_req.step       = acc;
    vote_req.full       = full;
    vote_req.clear      = in_last;
    vote_req.in_lab     = lab;
    vote_req.emit_lab   = cell_label[TOP];
    // label in the cell that shifts into the centre position
    vote_req.centre_lab = cell_label[CENTRE - 1];
  end

  lmw_vote #(
    .WINDOW_LEN  (WINDOW_LEN),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_vote (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (vote_req),
    .thr   (thr_r),
    .rsp   (vote_rsp)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    flush_nxt = flush_r;
    if (acc && in_last) begin
      flush_nxt = 1'b1;
    end else if (flush_done) begin
      flush_nxt = 1'b0;
    end
  end

  // output register: oldest label of a full window, or one label of the drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_label_nxt = out_label_r;
    out_last_nxt  = out_last_r;
    if (acc && full) begin
      // at least the rest of the window follows, so never the final transfer
      out_valid_nxt = 1'b1;
      out_label_nxt = cell_label[TOP];
      out_last_nxt  = 1'b0;
    end else if (flush_emit) begin
      out_valid_nxt = 1'b1;
      out_label_nxt = cell_label[TOP];
      out_last_nxt  = flush_done;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_label_r <= out_label_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_label = out_label_r;
  assign out_last  = out_last_r;

endmodule

[rtl/core/lmw_checker.sv]
// ----------------------------------------------------------------------------
// lmw_checker
// port-level checks of the label majority window filter
// ----------------------------------------------------------------------------
module lmw_checker #(
  parameter int unsigned NUM_CLASSES = lmw_pkg::NUM_CLASSES_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lmw_pkg::LABEL_W-1:0]  out_label,
  input logic                         out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_label) && $stable(out_last))
    else $error("result changed while stalled");

  // input only taken when the pending result can leave
  a_in_gated: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_ready)
    else $error("input ready with a blocked result");

  // a final label starts the drain
  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input ready right after a final label");

  // only real classes leave
  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_label} < (lmw_pkg::LABEL_W + 1)'(NUM_CLASSES)))
    else $error("result label out of range");

endmodule

bind label_majority_window_filter_unit lmw_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_lmw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_label (out_label),
  .out_last  (out_last)
);

[dv/label_filter_checker.sv]
// ----------------------------------------------------------------------------
// label_filter_checker
// watches both label streams and predicts the filtered label order
// ----------------------------------------------------------------------------
module label_filter_checker
  import lmw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [LABEL_W-1:0] in_label,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LABEL_W-1:0] out_label,
  input  logic               out_last,
  output int unsigned        mismatch_count,
  output int unsigned        pending_count
);

  localparam int unsigned WINDOW_LEN  = WINDOW_LEN_DEF;
  localparam int unsigned NUM_CLASSES = NUM_CLASSES_DEF;
  localparam int unsigned CENTRE      = WINDOW_LEN / 2;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               last;
  } filtered_label_t;

  // oldest label at index 0
  logic [LABEL_W-1:0] window_q [$];
  logic [THR_W-1:0]   class_count [NUM_CLASSES];
  logic [THR_W-1:0]   majority_thr;
  filtered_label_t    filtered_q [$];
  filtered_label_t    got;
  filtered_label_t    want;

  task automatic empty_window();
    window_q.delete();
    foreach (class_count[c]) class_count[c] = '0;
  endtask

  // one accepted label: vote on the centre, then emit what leaves the window
  task automatic filter_label(input logic [LABEL_W-1:0] raw, input logic is_last);
    logic [LABEL_W-1:0] lab;
    logic [LABEL_W-1:0] best;
    logic [LABEL_W-1:0] prev;
    int unsigned        n;
    lab = (raw >= NUM_CLASSES) ? '0 : raw;
    window_q.push_back(lab);
    class_count[lab]++;
    if (window_q.size() == WINDOW_LEN) begin
      best = '0;
      for (int c = 1; c < NUM_CLASSES; c++)
        if (class_count[c] > class_count[best]) best = LABEL_W'(c);
      prev = window_q[CENTRE];
      if (best != '0 && class_count[best] >= majority_thr && prev != best) begin
        class_count[prev]--;
        class_count[best]++;
        window_q[CENTRE] = best;
      end
    end
    if (is_last) begin
      n = window_q.size();
      for (int unsigned i = 0; i < n; i++)
        filtered_q.push_back('{label: window_q[i], last: (i == n - 1)});
      empty_window();
    end else if (window_q.size() == WINDOW_LEN) begin
      prev = window_q.pop_front();
      class_count[prev]--;
      filtered_q.push_back('{label: prev, last: 1'b0});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_window();
      filtered_q.delete();
      majority_thr   = THR_RESET;
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{label: out_label, last: out_last};
        if (filtered_q.size() == 0) begin
          mismatch_count++;
          $error("out_label: expected no transfer, actual %0d (out_last %0b)",
                 got.label, got.last);
        end else begin
          want = filtered_q.pop_front();
          if (got.label !== want.label) begin
            mismatch_count++;
            $error("out_label: expected %0d, actual %0d", want.label, got.label);
          end
          if (got.last !== want.last) begin
            mismatch_count++;
            $error("out_last: expected %0b, actual %0b", want.last, got.last);
          end
        end
      end
      // a label in the same cycle as a write still sees the old threshold
      if (in_valid && in_ready) filter_label(in_label, in_last);
      if (cfg_wr_en) majority_thr = cfg_wr_data;
    end
    pending_count = filtered_q.size();
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// label majority window filter: directed and random label sequences
// ----------------------------------------------------------------------------
// label sequences, each closed by a flush, are sent in bursts while the
// receiver stalls on its own pattern; a checker beside the block predicts
// every filtered label and compares it field by field. the threshold is
// changed between sequences only, once all labels have come out
// ----------------------------------------------------------------------------
module testbench;
  import lmw_pkg::*;

  localparam int unsigned WINDOW_LEN   = WINDOW_LEN_DEF;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned MIN_PHASES   = 5;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // a flushed chain drains a cell per unstalled cycle, plus the output register
  localparam int unsigned SETTLE       = WINDOW_LEN + 8;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [THR_W-1:0]   cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [LABEL_W-1:0] in_label    = '0;
  logic               in_last     = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [LABEL_W-1:0] out_label;
  logic               out_last;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned labels_sent  = 0;

  // receiver side state
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_left      = 0;
  logic [7:0]  ready_pattern  = 8'hff;
  int unsigned pattern_pos    = 0;

  label_majority_window_filter_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_label    (in_label),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_label   (out_label),
    .out_last    (out_last)
  );

  label_filter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_label       (in_label),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_label      (out_label),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: an 8-bit ready pattern, re-drawn periodically, sometimes
  // all ones; once per run a long hold so the window backs up into the input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      out_ready     <= 1'b0;
    end else begin
      if (pattern_pos % 32 == 0)
        ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hff
                                                    : (8'($urandom_range(0, 255)) | 8'h01);
      out_ready  <= ready_pattern[pattern_pos % 8];
      pattern_pos = (pattern_pos + 1) % 32;
    end
  end

  // one label transfer; the sender drops valid between bursts of random length
  task automatic send_label(input logic [LABEL_W-1:0] lab, input logic lst);
    in_valid <= 1'b1;
    in_label <= lab;
    in_last  <= lst;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // sender pause: every predicted label out, then let the chain settle
  task automatic wait_for_drain();
    if (in_valid) in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] thr);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int unsigned        phase;
    int unsigned        seq_len;
    int unsigned        mode;
    logic [LABEL_W-1:0] dom;
    logic [LABEL_W-1:0] lab;
    logic [THR_W-1:0]   thr;
    phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a short sequence passes unfiltered; out of range label 7 becomes 0
    for (int i = 0; i < 8; i++)
      send_label(LABEL_W'(i), i == 7);
    // a flush of a single label
    send_label(LABEL_W'(5), 1'b1);
    // alternating extremes ending in a flush
    for (int i = 0; i < 10; i++)
      send_label((i % 2 == 0) ? LABEL_W'(7) : LABEL_W'(0), i == 9);

    // random sequences, one threshold per phase, extremes first
    while (labels_sent < RANDOM_ITEMS || phase < MIN_PHASES) begin
      wait_for_drain();
      case (phase)
        0:       thr = '0;           // any nonzero majority wins
        1:       thr = THR_W'(1);
        2:       thr = THR_W'(WINDOW_LEN);
        3:       thr = '1;           // never reachable, no overwrite
        default: thr = ($urandom_range(0, 4) == 0) ? THR_RESET
                                                   : THR_W'($urandom_range(1, WINDOW_LEN));
      endcase
      set_threshold(thr);

      case ($urandom_range(0, 9))
        0, 1:    seq_len = $urandom_range(1, WINDOW_LEN - 1);
        2:       seq_len = WINDOW_LEN;
        3:       seq_len = WINDOW_LEN + 1;
        default: seq_len = $urandom_range(WINDOW_LEN + 2, 64);
      endcase
      // long receiver hold while this sequence keeps coming
      if (phase == 1) begin
        seq_len       = 100;
        long_hold_req = 1'b1;
      end

      // mode 0: one dominant class with noise
      // mode 1: dominant class against background, ties likely
      // mode 2: plain noise
      mode = $urandom_range(0, 2);
      dom  = LABEL_W'($urandom_range(1, NUM_CLASSES_DEF - 1));
      for (int unsigned k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          mode = $urandom_range(0, 2);
          dom  = LABEL_W'($urandom_range(1, NUM_CLASSES_DEF - 1));
        end
        case (mode)
          0:       lab = ($urandom_range(0, 9) < 7) ? dom : LABEL_W'($urandom_range(0, 7));
          1:       lab = ($urandom_range(0, 1) == 1) ? dom : '0;
          default: lab = LABEL_W'($urandom_range(0, 7));
        endcase
        send_label(lab, k == seq_len - 1);
        labels_sent++;
      end
      phase++;
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lmw_pkg.sv
rtl/core/lmw_cell.sv
rtl/core/lmw_vote.sv
rtl/core/label_majority_window_filter_unit.sv
rtl/core/lmw_checker.sv
dv/label_filter_checker.sv
dv/testbench.sv
